// ===== rtl/mmbd_pkg.sv =====
// mmbd_pkg: shared types and constants for the memory map bank decoder
// no dependencies
package mmbd_pkg;

  typedef enum logic [3:0] {
    TGT_LOCAL  = 4'd0,
    TGT_CART   = 4'd1,
    TGT_VRAM   = 4'd2,
    TGT_WRAM   = 4'd3,
    TGT_SPRITE = 4'd4,
    TGT_SOUND  = 4'd5,
    TGT_SERIAL = 4'd6,
    TGT_TIMER  = 4'd7,
    TGT_VIDEO  = 4'd8,
    TGT_SDMA   = 4'd9,
    TGT_BDMA   = 4'd10
  } target_e;

  // where the read byte of a local access comes from
  typedef enum logic [1:0] {
    SRC_REG  = 2'd0,
    SRC_HRAM = 2'd1,
    SRC_BGP  = 2'd2,
    SRC_OBP  = 2'd3
  } rd_src_e;

  localparam int unsigned TgtMax = 10;

  localparam logic [6:0] RegJoyp = 7'h00;
  localparam logic [6:0] RegIf   = 7'h0F;
  localparam logic [6:0] RegLy   = 7'h44;
  localparam logic [6:0] RegDma  = 7'h46;
  localparam logic [6:0] RegKey1 = 7'h4D;
  localparam logic [6:0] RegVbk  = 7'h4F;
  localparam logic [6:0] RegHdma = 7'h55;
  localparam logic [6:0] RegBcps = 7'h68;
  localparam logic [6:0] RegBcpd = 7'h69;
  localparam logic [6:0] RegOcps = 7'h6A;
  localparam logic [6:0] RegOcpd = 7'h6B;
  localparam logic [6:0] RegSvbk = 7'h70;

  localparam logic [7:0] OpenBus = 8'hFF;

endpackage

// ===== rtl/memory_map_bank_decoder.sv =====
// memory_map_bank_decoder: cpu bus region decode, bank translation and local registers
// depends on mmbd_pkg
//
//  channel | direction | handshake         | payload
//  in      | in        | in_valid/in_stall | req_type, address, write_data, status bits
//  out     | out       | out_valid/stall   | target, local_offset, read_data
//  cfg     | in        | apb               | color_mode at byte address 0
//
// one word per cycle while the output is not stalled; each word reaches the output register
// in the cycle after it is taken, with the registered read of the high ram and palette memories.
// a new word is taken in the same cycle the previous result leaves.
// reset marks every memory entry invalid (reads as zero), no clearing pass.
// a stalled output holds; the input is stalled only while it holds.
module memory_map_bank_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        video_ram_open_i,
  input  logic        sprite_ram_open_i,
  input  logic        sprite_dma_busy_i,
  input  logic [7:0]  buttons_held_i,
  input  logic        speed_state_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  target_o,
  output logic [15:0] local_offset_o,
  output logic [7:0]  read_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        accept;
  logic        cm_q;
  logic [7:0]  bg_idx_q, bg_idx_d, obj_idx_q, obj_idx_d, ie_q, ie_d, dma_q, dma_d;
  logic        vbk_q, vbk_d, ssr_q, ssr_d;
  logic [2:0]  wbk_q, wbk_d;
  logic [4:0]  if_q, if_d;
  logic [1:0]  js_q, js_d;

  logic [7:0]  hram_mem [127];
  // background palette in the lower half, object palette in the upper half
  logic [7:0]  pal_mem [128];
  logic [126:0] hram_vld_q;
  logic [127:0] pal_vld_q;
  logic [7:0]  hram_rd_q, pal_rd_q;
  logic        mem_vld_q;
  logic [6:0]  pal_addr;
  logic        pal_we;

  logic        out_valid_q;
  mmbd_pkg::target_e tgt_d, tgt_q;
  logic [15:0] off_d, off_q;
  logic [7:0]  rd_d, rd_q;
  mmbd_pkg::rd_src_e src_d, src_q;
  logic        hram_we, bgp_we, obp_we;

  logic        wr, cm;
  logic [6:0]  r;
  logic [2:0]  bank;
  logic [3:0]  joy_lo;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign pready     = 1'b1;
  assign prdata     = {31'd0, cm_q & ~paddr[2]};
  assign wr = req_type_i;
  assign cm = cm_q;
  assign r  = address_i[6:0];
  assign pal_we = bgp_we | obp_we;

  always_comb begin
    bank = cm ? wbk_q : 3'd1;
    if (bank == 3'd0) begin
      bank = 3'd1;
    end
    joy_lo = 4'hF;
    if (!js_q[0]) joy_lo = joy_lo & ~buttons_held_i[3:0];
    if (!js_q[1]) joy_lo = joy_lo & ~buttons_held_i[7:4];
    pal_addr = (r == mmbd_pkg::RegOcpd) ? {1'b1, obj_idx_q[5:0]} : {1'b0, bg_idx_q[5:0]};
  end

  always_comb begin
    tgt_d = mmbd_pkg::TGT_LOCAL;
    off_d = address_i;
    rd_d  = mmbd_pkg::OpenBus;
    src_d = mmbd_pkg::SRC_REG;
    hram_we = 1'b0;
    bgp_we  = 1'b0;
    obp_we  = 1'b0;
    bg_idx_d = bg_idx_q;
    obj_idx_d = obj_idx_q;
    ie_d = ie_q;
    dma_d = dma_q;
    vbk_d = vbk_q;
    ssr_d = ssr_q;
    wbk_d = wbk_q;
    if_d = if_q;
    js_d = js_q;
    if (address_i < 16'h8000 || (address_i >= 16'hA000 && address_i < 16'hC000)) begin
      tgt_d = mmbd_pkg::TGT_CART;
    end else if (address_i < 16'hA000) begin
      if (video_ram_open_i) begin
        tgt_d = mmbd_pkg::TGT_VRAM;
        off_d = {2'b00, vbk_q, address_i[12:0]};
      end
    end else if (address_i < 16'hFE00) begin
      // echo region lands on the same offsets, bit 12 picks the banked half
      tgt_d = mmbd_pkg::TGT_WRAM;
      off_d = address_i[12] ? {1'b0, bank, address_i[11:0]} : {4'd0, address_i[11:0]};
    end else if (address_i < 16'hFEA0) begin
      if (!sprite_dma_busy_i && sprite_ram_open_i) begin
        tgt_d = mmbd_pkg::TGT_SPRITE;
        off_d = {8'd0, address_i[7:0]};
      end
    end else if (address_i < 16'hFF00) begin
      tgt_d = mmbd_pkg::TGT_LOCAL;
    end else if (address_i < 16'hFF80) begin
      case (r) inside
        [7'h10:7'h26], [7'h30:7'h3F]: tgt_d = mmbd_pkg::TGT_SOUND;
        7'h01, 7'h02:                 tgt_d = mmbd_pkg::TGT_SERIAL;
        [7'h04:7'h07]:                tgt_d = mmbd_pkg::TGT_TIMER;
        mmbd_pkg::RegLy: begin
          if (!wr) tgt_d = mmbd_pkg::TGT_VIDEO;
        end
        [7'h40:7'h43], [7'h45:7'h45], [7'h47:7'h4B]: tgt_d = mmbd_pkg::TGT_VIDEO;
        mmbd_pkg::RegJoyp: begin
          if (wr) js_d = write_data_i[5:4];
          else rd_d = {2'b11, js_q, joy_lo};
        end
        mmbd_pkg::RegIf: begin
          if (wr) if_d = write_data_i[4:0];
          else rd_d = {3'b111, if_q};
        end
        mmbd_pkg::RegDma: begin
          if (wr) begin
            dma_d = write_data_i;
            tgt_d = mmbd_pkg::TGT_SDMA;
          end else begin
            rd_d = dma_q;
          end
        end
        [7'h51:7'h54]: begin
          if (wr) tgt_d = mmbd_pkg::TGT_BDMA;
        end
        mmbd_pkg::RegHdma: begin
          if (cm) tgt_d = mmbd_pkg::TGT_BDMA;
        end
        mmbd_pkg::RegKey1: begin
          if (cm) begin
            if (wr) ssr_d = write_data_i[0];
            else rd_d = {speed_state_i, 6'b111111, ssr_q};
          end
        end
        mmbd_pkg::RegVbk: begin
          if (cm) begin
            if (wr) vbk_d = write_data_i[0];
            else rd_d = {7'b1111111, vbk_q};
          end
        end
        mmbd_pkg::RegSvbk: begin
          if (cm) begin
            if (wr) wbk_d = write_data_i[2:0];
            else rd_d = {5'b11111, wbk_q};
          end
        end
        mmbd_pkg::RegBcps: begin
          if (cm) begin
            if (wr) bg_idx_d = write_data_i;
            else rd_d = bg_idx_q;
          end
        end
        mmbd_pkg::RegBcpd: begin
          if (cm) begin
            if (wr) begin
              bgp_we = 1'b1;
              if (bg_idx_q[7]) bg_idx_d = {2'b10, bg_idx_q[5:0] + 6'd1};
            end else begin
              src_d = mmbd_pkg::SRC_BGP;
            end
          end
        end
        mmbd_pkg::RegOcps: begin
          if (cm) begin
            if (wr) obj_idx_d = write_data_i;
            else rd_d = obj_idx_q;
          end
        end
        mmbd_pkg::RegOcpd: begin
          if (cm) begin
            if (wr) begin
              obp_we = 1'b1;
              if (obj_idx_q[7]) obj_idx_d = {2'b10, obj_idx_q[5:0] + 6'd1};
            end else begin
              src_d = mmbd_pkg::SRC_OBP;
            end
          end
        end
        default: rd_d = mmbd_pkg::OpenBus;
      endcase
    end else if (address_i < 16'hFFFF) begin
      if (wr) hram_we = 1'b1;
      else src_d = mmbd_pkg::SRC_HRAM;
    end else begin
      if (wr) ie_d = write_data_i;
      else rd_d = ie_q;
    end
    if (wr || tgt_d != mmbd_pkg::TGT_LOCAL) begin
      rd_d  = 8'd0;
      src_d = mmbd_pkg::SRC_REG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q <= 1'b0;
      bg_idx_q <= '0;
      obj_idx_q <= '0;
      ie_q <= '0;
      dma_q <= '0;
      vbk_q <= 1'b0;
      ssr_q <= 1'b0;
      wbk_q <= '0;
      if_q <= '0;
      js_q <= '0;
      hram_vld_q <= '0;
      pal_vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        cm_q <= pwdata[0];
      end
      if (accept) begin
        bg_idx_q <= bg_idx_d;
        obj_idx_q <= obj_idx_d;
        ie_q <= ie_d;
        dma_q <= dma_d;
        vbk_q <= vbk_d;
        ssr_q <= ssr_d;
        wbk_q <= wbk_d;
        if_q <= if_d;
        js_q <= js_d;
        if (hram_we) hram_vld_q[address_i[6:0]] <= 1'b1;
        if (pal_we) pal_vld_q[pal_addr] <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memories: write and registered read on the accept edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (hram_we) hram_mem[address_i[6:0]] <= write_data_i;
      if (pal_we) pal_mem[pal_addr] <= write_data_i;
      hram_rd_q <= hram_mem[address_i[6:0]];
      pal_rd_q  <= pal_mem[pal_addr];
      case (src_d)
        mmbd_pkg::SRC_HRAM: mem_vld_q <= hram_vld_q[address_i[6:0]];
        mmbd_pkg::SRC_BGP:  mem_vld_q <= pal_vld_q[pal_addr];
        mmbd_pkg::SRC_OBP:  mem_vld_q <= pal_vld_q[pal_addr];
        default:            mem_vld_q <= 1'b0;
      endcase
      tgt_q <= tgt_d;
      off_q <= off_d;
      rd_q  <= rd_d;
      src_q <= src_d;
    end
  end

  always_comb begin
    case (src_q)
      mmbd_pkg::SRC_HRAM: read_data_o = mem_vld_q ? hram_rd_q : 8'd0;
      mmbd_pkg::SRC_BGP:  read_data_o = mem_vld_q ? pal_rd_q : 8'd0;
      mmbd_pkg::SRC_OBP:  read_data_o = mem_vld_q ? pal_rd_q : 8'd0;
      default:            read_data_o = rd_q;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign target_o       = tgt_q;
  assign local_offset_o = off_q;

endmodule

// ===== rtl/mmbd_checker.sv =====
// mmbd_checker: port-level assertions for memory_map_bank_decoder, bound into that module
// depends on mmbd_pkg
module mmbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  target_o,
  input logic [15:0] local_offset_o,
  input logic [7:0]  read_data_o
);

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o != 4'(mmbd_pkg::TGT_LOCAL) |-> read_data_o == 8'd0)
    else $error("read data not zero for a routed word");

  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> target_o <= 4'(mmbd_pkg::TgtMax))
    else $error("target code out of range");

  a_sprite_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == 4'(mmbd_pkg::TGT_SPRITE) |-> local_offset_o < 16'hA0)
    else $error("sprite offset out of range");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word not shown");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(target_o)
      && $stable(local_offset_o) && $stable(read_data_o))
    else $error("stalled output changed");

endmodule

bind memory_map_bank_decoder mmbd_checker u_mmbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .target_o      (target_o),
  .local_offset_o(local_offset_o),
  .read_data_o   (read_data_o)
);

// ===== dv/tb.sv =====
// tb: self-checking testbench for memory_map_bank_decoder
// drives bus accesses and apb register writes, predicts each decoded word
// depends on mmbd_pkg and the rtl of memory_map_bank_decoder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        vopen;
    logic        sopen;
    logic        sbusy;
    logic [7:0]  keys;
    logic        speed;
  } access_t;

  typedef struct packed {
    logic [3:0]  tgt;
    logic [15:0] off;
    logic [7:0]  rdata;
  } decode_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [15:0] address_i = '0;
  logic [7:0] write_data_i = '0;
  logic video_ram_open_i = 1'b0;
  logic sprite_ram_open_i = 1'b0;
  logic sprite_dma_busy_i = 1'b0;
  logic [7:0] buttons_held_i = '0;
  logic speed_state_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] target_o;
  logic [15:0] local_offset_o;
  logic [7:0] read_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #6 clk_i = ~clk_i;

  memory_map_bank_decoder i_dut (.*);

  // predictor state
  logic       m_color;
  logic [7:0] m_io [128];
  logic [7:0] m_hram [127];
  logic [7:0] m_bgp [64];
  logic [7:0] m_obp [64];
  logic [7:0] m_bg_idx, m_obj_idx, m_ie;
  logic       m_vbank, m_speed_req;
  logic [2:0] m_wbank;
  logic [4:0] m_if;
  logic [1:0] m_joy_sel;

  decode_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_mode = 0;

  logic [15:0] spots_colour [] = '{16'hFF4D, 16'hFF4F, 16'hFF70, 16'hFF68, 16'hFF69,
    16'hFF6A, 16'hFF6B, 16'hFF55, 16'hFF00, 16'hFF0F};

  function automatic logic [15:0] wram_offset(logic [15:0] a);
    logic [3:0] bank;
    if (a < 16'hD000) return a - 16'hC000;
    bank = m_color ? {1'b0, m_wbank} : 4'd1;
    if (bank == 0) bank = 4'd1;
    return {bank, 12'h000} + (a - 16'hD000);
  endfunction

  function automatic logic [7:0] step_index(logic [7:0] idx);
    return idx[7] ? {2'b10, 6'(idx[5:0] + 6'd1)} : idx;
  endfunction

  function automatic decode_t decode_access(access_t x);
    decode_t d;
    logic [7:0] r;
    logic [7:0] sel;
    logic [6:0] hi;
    d.tgt = mmbd_pkg::TGT_LOCAL;
    d.off = x.addr;
    d.rdata = mmbd_pkg::OpenBus;
    if (x.addr < 16'h8000 || (x.addr >= 16'hA000 && x.addr < 16'hC000))
      d.tgt = mmbd_pkg::TGT_CART;
    else if (x.addr < 16'hA000) begin
      if (x.vopen) begin
        d.tgt = mmbd_pkg::TGT_VRAM;
        d.off = {2'b00, m_vbank, 13'h0} + (x.addr - 16'h8000);
      end
    end else if (x.addr < 16'hE000) begin
      d.tgt = mmbd_pkg::TGT_WRAM;
      d.off = wram_offset(x.addr);
    end else if (x.addr < 16'hFE00) begin
      d.tgt = mmbd_pkg::TGT_WRAM;
      d.off = wram_offset(x.addr - 16'h2000);
    end else if (x.addr < 16'hFEA0) begin
      if (!x.sbusy && x.sopen) begin
        d.tgt = mmbd_pkg::TGT_SPRITE;
        d.off = x.addr - 16'hFE00;
      end
    end else if (x.addr < 16'hFF00) begin
      // unusable hole reads open bus
    end else if (x.addr < 16'hFF80) begin
      r = x.addr[7:0];
      if ((r >= 8'h10 && r <= 8'h26) || (r >= 8'h30 && r <= 8'h3F))
        d.tgt = mmbd_pkg::TGT_SOUND;
      else if (r == 8'h01 || r == 8'h02) d.tgt = mmbd_pkg::TGT_SERIAL;
      else if (r >= 8'h04 && r <= 8'h07) d.tgt = mmbd_pkg::TGT_TIMER;
      else if (r == mmbd_pkg::RegLy) begin
        if (!x.wr) d.tgt = mmbd_pkg::TGT_VIDEO;
      end else if (r >= 8'h40 && r <= 8'h4B && r != mmbd_pkg::RegDma)
        d.tgt = mmbd_pkg::TGT_VIDEO;
      else if (r == mmbd_pkg::RegJoyp) begin
        if (x.wr) m_joy_sel = x.wdata[5:4];
        else begin
          sel = {2'b00, m_joy_sel, 4'h0};
          d.rdata = 8'hC0 | sel | 8'h0F;
          if (!sel[4]) d.rdata &= ~{4'h0, x.keys[3:0]};
          if (!sel[5]) d.rdata &= ~{4'h0, x.keys[7:4]};
        end
      end else if (r == mmbd_pkg::RegIf) begin
        if (x.wr) m_if = x.wdata[4:0];
        else d.rdata = {3'b111, m_if};
      end else if (r == mmbd_pkg::RegDma) begin
        if (x.wr) begin
          m_io[mmbd_pkg::RegDma] = x.wdata;
          d.tgt = mmbd_pkg::TGT_SDMA;
        end else d.rdata = m_io[mmbd_pkg::RegDma];
      end else if (r >= 8'h51 && r <= 8'h54) begin
        if (x.wr) d.tgt = mmbd_pkg::TGT_BDMA;
      end else if (r == mmbd_pkg::RegHdma) begin
        if (m_color) d.tgt = mmbd_pkg::TGT_BDMA;
      end else if (r == mmbd_pkg::RegKey1) begin
        if (m_color) begin
          if (x.wr) m_speed_req = x.wdata[0];
          else d.rdata = {x.speed, 6'b111111, m_speed_req};
        end
      end else if (r == mmbd_pkg::RegVbk) begin
        if (m_color) begin
          if (x.wr) m_vbank = x.wdata[0];
          else d.rdata = {7'b1111111, m_vbank};
        end
      end else if (r == mmbd_pkg::RegSvbk) begin
        if (m_color) begin
          if (x.wr) m_wbank = x.wdata[2:0];
          else d.rdata = {5'b11111, m_wbank};
        end
      end else if (r == mmbd_pkg::RegBcps) begin
        if (m_color) begin
          if (x.wr) m_bg_idx = x.wdata;
          else d.rdata = m_bg_idx;
        end
      end else if (r == mmbd_pkg::RegBcpd) begin
        if (m_color) begin
          if (x.wr) begin
            m_bgp[m_bg_idx[5:0]] = x.wdata;
            m_bg_idx = step_index(m_bg_idx);
          end else d.rdata = m_bgp[m_bg_idx[5:0]];
        end
      end else if (r == mmbd_pkg::RegOcps) begin
        if (m_color) begin
          if (x.wr) m_obj_idx = x.wdata;
          else d.rdata = m_obj_idx;
        end
      end else if (r == mmbd_pkg::RegOcpd) begin
        if (m_color) begin
          if (x.wr) begin
            m_obp[m_obj_idx[5:0]] = x.wdata;
            m_obj_idx = step_index(m_obj_idx);
          end else d.rdata = m_obp[m_obj_idx[5:0]];
        end
      end else if (x.wr) m_io[r[6:0]] = x.wdata;
    end else if (x.addr < 16'hFFFF) begin
      hi = x.addr[6:0];
      if (x.wr) m_hram[hi] = x.wdata;
      else d.rdata = m_hram[hi];
    end else begin
      if (x.wr) m_ie = x.wdata;
      else d.rdata = m_ie;
    end
    if (x.wr || d.tgt != mmbd_pkg::TGT_LOCAL) d.rdata = 8'h00;
    return d;
  endfunction

  task automatic send_access(access_t x);
    expected_words.push_back(decode_access(x));
    in_valid_i <= 1'b1;
    {req_type_i, address_i, write_data_i, video_ram_open_i, sprite_ram_open_i,
     sprite_dma_busy_i, buttons_held_i, speed_state_i} <= x;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    // bursts with random gaps between them
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic idle_sender();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    idle_sender();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_color(logic value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {31'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    m_color = value;
  endtask

  function automatic access_t any_access();
    access_t x;
    x = access_t'(37'({$urandom, $urandom}));
    return x;
  endfunction

  function automatic access_t reg_access(logic wr, logic [15:0] a, logic [7:0] v);
    access_t x;
    x = any_access();
    x.wr = wr;
    x.addr = a;
    x.wdata = v;
    return x;
  endfunction

  // the region boundaries (but for ff00) and the ly, dma and hdma registers, both directions
  task automatic test_directed();
    logic [15:0] spots [] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF,
      16'hC000, 16'hCFFF, 16'hD000, 16'hDFFF, 16'hE000, 16'hFDFF, 16'hFE00, 16'hFE9F,
      16'hFEA0, 16'hFEFF, 16'hFF44, 16'hFF46, 16'hFF51, 16'hFF55, 16'hFF7F, 16'hFF80,
      16'hFFFE, 16'hFFFF};
    foreach (spots[i]) begin
      send_access(reg_access(1'b1, spots[i], 8'hFF));
      send_access(reg_access(1'b0, spots[i], 8'h00));
    end
  endtask

  // colour registers: banks, palette auto-increment with wrap, speed
  task automatic test_colour_regs();
    send_access(reg_access(1'b1, 16'hFF70, 8'h00));
    send_access(reg_access(1'b0, 16'hD123, 8'h00));
    send_access(reg_access(1'b1, 16'hFF70, 8'h07));
    send_access(reg_access(1'b1, 16'hFF4F, 8'h01));
    send_access(reg_access(1'b0, 16'h9FFF, 8'h00));
    send_access(reg_access(1'b1, 16'hFF68, 8'hBE));
    repeat (4) send_access(reg_access(1'b1, 16'hFF69, 8'($urandom)));
    send_access(reg_access(1'b1, 16'hFF6A, 8'h3F));
    repeat (2) send_access(reg_access(1'b1, 16'hFF6B, 8'($urandom)));
    foreach (spots_colour[i]) send_access(reg_access(1'b0, spots_colour[i], 8'h00));
    send_access(reg_access(1'b1, 16'hFF4D, 8'h01));
  endtask

  function automatic access_t random_access();
    access_t x;
    x = any_access();
    case ($urandom_range(0, 9))
      0, 1, 2: x.addr = {8'hFF, 8'($urandom_range(0, 127))};
      3:       x.addr = {8'hFF, 1'b1, 7'($urandom)};
      4:       x.addr = 16'hFF68 + 16'($urandom_range(0, 3));
      5:       x.addr = 16'hFE00 + 16'($urandom_range(0, 255));
      6:       x.addr = spots_colour[$urandom_range(0, spots_colour.size() - 1)];
      default: ;
    endcase
    return x;
  endfunction

  task automatic test_random(int unsigned count);
    repeat (count) send_access(random_access());
  endtask

  // sender holds off until everything is back, then carries on
  task automatic test_quiet_pause();
    test_random(30);
    idle_sender();
    while (expected_words.size() != 0) @(negedge clk_i);
    test_random(30);
  endtask

  // receiver stall pattern: phases of none, heavy and periodic stalling
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) != 0);
        default: out_stall_i <= (cycles % 3 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    decode_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: tgt %0d off %h rd %h",
          target_o, local_offset_o, read_data_o);
      end else begin
        want = expected_words.pop_front();
        if (target_o !== want.tgt || local_offset_o !== want.off ||
            read_data_o !== want.rdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected tgt %0d off %h rd %h, got tgt %0d off %h rd %h",
              want.tgt, want.off, want.rdata, target_o, local_offset_o, read_data_o);
        end
      end
    end
  end

  initial begin
    m_color = 1'b0;
    foreach (m_io[i]) m_io[i] = '0;
    foreach (m_hram[i]) m_hram[i] = '0;
    foreach (m_bgp[i]) m_bgp[i] = '0;
    foreach (m_obp[i]) m_obp[i] = '0;
    {m_bg_idx, m_obj_idx, m_ie, m_vbank, m_speed_req, m_wbank, m_if, m_joy_sel} = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_colour_regs();
    test_random(300);
    write_color(1'b1);
    test_directed();
    test_colour_regs();
    test_random(350);
    test_quiet_pause();
    write_color(1'b0);
    test_random(250);
    write_color(1'b1);
    test_random(200);
    drain();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
